// ----- rtl/alm_pkg.sv -----
// ----------------------------------------------------------------------------
// alm_pkg
// shared constants, codes and command/status types for the linked list manager
// ----------------------------------------------------------------------------
package alm_pkg;

   localparam int SLOT_COUNT  = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
   localparam int LINK_BITS   = $clog2(SLOT_COUNT + 1);
   localparam int COUNT_BITS  = $clog2(SLOT_COUNT + 1);
   localparam int STEP_BITS   = $clog2(SLOT_COUNT + 2);

   localparam logic [LINK_BITS-1:0] NIL_LINK = LINK_BITS'(SLOT_COUNT);

   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_DEL_FRONT = 3'd2,
      CMD_DEL_BACK  = 3'd3,
      CMD_DEL_VALUE = 3'd4,
      CMD_SEARCH    = 3'd5
   } command_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   // pointer selects for the datapath walk register
   typedef enum logic [1:0] {
      PSEL_HOLD = 2'd0,
      PSEL_HEAD = 2'd1,
      PSEL_NEXT = 2'd2
   } psel_type;

   // link write sources
   typedef enum logic [2:0] {
      LW_NONE      = 3'd0,
      LW_NEW_HEAD  = 3'd1,
      LW_PREV_NEW  = 3'd2,
      LW_PREV_NIL  = 3'd3,
      LW_PREV_SKIP = 3'd4,
      LW_HEAD_NIL  = 3'd5,
      LW_HEAD_SKIP = 3'd6,
      LW_HEAD_NEW  = 3'd7
   } lwrite_type;

   typedef struct packed {
      logic                    load_item;
      psel_type                psel;
      logic                    save_prev;
      logic                    clear_prev;
      lwrite_type              lwrite;
      logic                    alloc;
      logic                    free_cur;
      logic                    take_removed;
      logic                    set_slot;
      logic [1:0]              status;
      logic                    max_init;
      logic                    max_update;
      logic                    rsp_load;
   } ctrl_type;

   typedef struct packed {
      command_type             cmd;
      logic                    cmd_valid;
      logic                    head_nil;
      logic                    full;
      logic                    cur_nil;
      logic                    next_nil;
      logic                    match;
      logic [STEP_BITS-1:0]    steps;
   } stat_type;

endpackage

// ----- rtl/alm_if.sv -----
// ----------------------------------------------------------------------------
// alm_req_if / alm_rsp_if
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface alm_req_if;
   logic                         valid;
   logic                         ready;
   logic [2:0]                   command;
   logic signed [alm_pkg::VALUE_WIDTH-1:0] value;
   modport source (output valid, command, value, input ready);
   modport sink (input valid, command, value, output ready);
endinterface

interface alm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [3:0]                   slot_index;
   logic signed [31:0]           removed_value;
   logic [4:0]                   element_count;
   logic signed [31:0]           max_value;
   logic                         list_empty;
   modport source (output valid, status, slot_index, removed_value, element_count,
                   max_value, list_empty, input ready);
   modport sink (input valid, status, slot_index, removed_value, element_count,
                 max_value, list_empty, output ready);
endinterface

// ----- rtl/alm_datapath.sv -----
// ----------------------------------------------------------------------------
// alm_datapath
// slot memories, head pointer, occupancy bitmap, walk pointers and result regs
// ----------------------------------------------------------------------------
module alm_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [2:0]                     in_command,
   input  logic [alm_pkg::VALUE_WIDTH-1:0] in_value,
   input  alm_pkg::ctrl_type              ctrl,
   output alm_pkg::stat_type              stat,
   output logic [1:0]                     out_status,
   output logic [3:0]                     out_slot,
   output logic [31:0]                    out_removed,
   output logic [4:0]                     out_count,
   output logic [31:0]                    out_max,
   output logic                           out_empty
);
   import alm_pkg::*;

   logic [LINK_BITS-1:0]   next_link_ff [SLOT_COUNT];
   logic [VALUE_WIDTH-1:0] slot_value_ff [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  occupied_ff;
   logic [LINK_BITS-1:0]   head_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [2:0]             cmd_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [LINK_BITS-1:0]   cur_ff, prev_ff, new_ff;
   logic [STEP_BITS-1:0]   steps_ff;
   logic [VALUE_WIDTH-1:0] removed_ff, max_ff;
   logic [SLOT_BITS-1:0]   slot_ff;
   logic [1:0]             status_ff;
   logic [1:0]             rsp_status_ff;
   logic [3:0]             rsp_slot_ff;
   logic [31:0]            rsp_removed_ff, rsp_max_ff;
   logic [4:0]             rsp_count_ff;
   logic                   rsp_empty_ff;

   logic                   cur_nil;
   logic [SLOT_BITS-1:0]   cur_idx, prev_idx, new_idx;
   logic [LINK_BITS-1:0]   cur_next;
   logic [VALUE_WIDTH-1:0] cur_val;
   logic [SLOT_BITS-1:0]   free_idx;
   logic                   full;
   logic [LINK_BITS-1:0]   ptr_in;

   assign cur_nil  = cur_ff >= NIL_LINK;
   assign cur_idx  = cur_ff[SLOT_BITS-1:0];
   assign prev_idx = prev_ff[SLOT_BITS-1:0];
   assign new_idx  = new_ff[SLOT_BITS-1:0];
   assign cur_next = (cur_nil || next_link_ff[cur_idx] >= NIL_LINK) ? NIL_LINK
                                                                    : next_link_ff[cur_idx];
   assign cur_val  = slot_value_ff[cur_idx];
   assign full     = &occupied_ff;

   always_comb begin
      free_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!occupied_ff[i]) free_idx = SLOT_BITS'(i);
      end
   end

   always_comb begin
      case (ctrl.psel)
         PSEL_HEAD: ptr_in = head_ff;
         PSEL_NEXT: ptr_in = cur_next;
         default:   ptr_in = cur_ff;
      endcase
   end

   assign stat.cmd       = command_type'(cmd_ff);
   assign stat.cmd_valid = cmd_ff <= 3'(CMD_SEARCH);
   assign stat.head_nil  = head_ff >= NIL_LINK;
   assign stat.full      = full;
   assign stat.cur_nil   = cur_nil;
   assign stat.next_nil  = cur_next >= NIL_LINK;
   assign stat.match     = !cur_nil && cur_val == val_ff;
   assign stat.steps     = steps_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load_item) begin
         cmd_ff     <= in_command;
         val_ff     <= in_value;
         removed_ff <= '0;
         slot_ff    <= '0;
         status_ff  <= ST_OK;
      end
      if (ctrl.psel != PSEL_HOLD) begin
         cur_ff   <= ptr_in;
         steps_ff <= (ctrl.psel == PSEL_HEAD) ? '0 : steps_ff + 1'b1;
      end
      if (ctrl.clear_prev) prev_ff <= NIL_LINK;
      else if (ctrl.save_prev) prev_ff <= cur_ff;
      if (ctrl.take_removed) removed_ff <= cur_val;
      if (ctrl.set_slot) slot_ff <= cur_idx;
      if (ctrl.status != ST_OK) status_ff <= ctrl.status;
      if (ctrl.alloc) begin
         new_ff                  <= LINK_BITS'(free_idx);
         slot_ff                 <= free_idx;
         slot_value_ff[free_idx] <= val_ff;
      end
      if (ctrl.max_init) max_ff <= '0;
      if (ctrl.max_update && !cur_nil &&
          (steps_ff == '0 || $signed(cur_val) > $signed(max_ff))) max_ff <= cur_val;
      if (ctrl.rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_slot_ff    <= 4'(slot_ff);
         rsp_removed_ff <= 32'(removed_ff);
         rsp_count_ff   <= 5'(count_ff);
         rsp_max_ff     <= 32'(max_ff);
         rsp_empty_ff   <= head_ff >= NIL_LINK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= NIL_LINK;
         occupied_ff <= '0;
         count_ff    <= '0;
         for (int i = 0; i < SLOT_COUNT; i++) next_link_ff[i] <= NIL_LINK;
      end else begin
         if (ctrl.alloc) begin
            occupied_ff[free_idx]  <= 1'b1;
            next_link_ff[free_idx] <= NIL_LINK;
            count_ff               <= count_ff + 1'b1;
         end
         if (ctrl.free_cur) begin
            occupied_ff[cur_idx]  <= 1'b0;
            next_link_ff[cur_idx] <= NIL_LINK;
            count_ff              <= count_ff - 1'b1;
         end
         case (ctrl.lwrite)
            LW_NEW_HEAD: begin
               next_link_ff[new_idx] <= head_ff;
               head_ff               <= new_ff;
            end
            LW_HEAD_NEW:  head_ff <= new_ff;
            LW_PREV_NEW:  next_link_ff[prev_idx] <= new_ff;
            LW_PREV_NIL:  next_link_ff[prev_idx] <= NIL_LINK;
            LW_PREV_SKIP: next_link_ff[prev_idx] <= cur_next;
            LW_HEAD_NIL:  head_ff <= NIL_LINK;
            LW_HEAD_SKIP: head_ff <= cur_next;
            default: ;
         endcase
      end
   end

   assign out_status  = rsp_status_ff;
   assign out_slot    = rsp_slot_ff;
   assign out_removed = rsp_removed_ff;
   assign out_count   = rsp_count_ff;
   assign out_max     = rsp_max_ff;
   assign out_empty   = rsp_empty_ff;

endmodule

// ----- rtl/alm_controller.sv -----
// ----------------------------------------------------------------------------
// alm_controller
// command sequencer: walks the chain, edits links, scans for the maximum
// ----------------------------------------------------------------------------
module alm_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  alm_pkg::stat_type stat,
   output alm_pkg::ctrl_type ctrl
);
   import alm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_INS_LINK, S_WALK_BACK, S_DEL_BACK, S_FIND,
      S_MAX_START, S_MAX_WALK, S_RESULT, S_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      ctrl         = '0;
      ctrl.psel    = PSEL_HOLD;
      ctrl.lwrite  = LW_NONE;
      ctrl.status  = ST_OK;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load_item = 1'b1;
               state_in       = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            ctrl.psel       = PSEL_HEAD;
            ctrl.clear_prev = 1'b1;
            state_in        = S_MAX_START;
            if (!stat.cmd_valid) begin
               state_in = S_MAX_START;
            end else if (stat.cmd == CMD_INS_FRONT || stat.cmd == CMD_INS_BACK) begin
               if (stat.full) ctrl.status = ST_FULL;
               else begin
                  ctrl.alloc = 1'b1;
                  state_in   = S_INS_LINK;
               end
            end else if (stat.cmd == CMD_SEARCH) begin
               state_in = S_FIND;
            end else if (stat.head_nil) begin
               ctrl.status = ST_EMPTY;
            end else if (stat.cmd == CMD_DEL_VALUE) begin
               state_in = S_FIND;
            end else begin
               state_in = S_WALK_BACK;
            end
         end
         S_INS_LINK: begin
            if (stat.cmd == CMD_INS_FRONT) begin
               ctrl.lwrite = LW_NEW_HEAD;
               state_in    = S_MAX_START;
            end else if (stat.head_nil) begin
               ctrl.lwrite = LW_HEAD_NEW;
               state_in    = S_MAX_START;
            end else if (stat.next_nil || stat.steps >= STEP_BITS'(SLOT_COUNT)) begin
               ctrl.save_prev = 1'b1;
               state_in       = S_WALK_BACK;
            end else begin
               ctrl.psel = PSEL_NEXT;
            end
         end
         S_WALK_BACK: begin
            if (stat.cmd == CMD_INS_BACK) begin
               ctrl.lwrite = LW_PREV_NEW;
               state_in    = S_MAX_START;
            end else if (stat.cmd == CMD_DEL_FRONT ||
                         stat.next_nil || stat.steps >= STEP_BITS'(SLOT_COUNT)) begin
               state_in = S_DEL_BACK;
            end else begin
               ctrl.save_prev = 1'b1;
               ctrl.psel      = PSEL_NEXT;
            end
         end
         S_DEL_BACK: begin
            ctrl.take_removed = 1'b1;
            ctrl.set_slot     = 1'b1;
            ctrl.free_cur     = 1'b1;
            if (stat.cmd == CMD_DEL_FRONT) ctrl.lwrite = LW_HEAD_SKIP;
            else ctrl.lwrite = stat.steps == '0 ? LW_HEAD_NIL : LW_PREV_NIL;
            state_in = S_MAX_START;
         end
         S_FIND: begin
            if (stat.cur_nil) begin
               ctrl.status = ST_NOTFOUND;
               state_in    = S_MAX_START;
            end else if (stat.match) begin
               ctrl.set_slot = 1'b1;
               if (stat.cmd == CMD_DEL_VALUE) begin
                  ctrl.free_cur = 1'b1;
                  ctrl.lwrite   = stat.steps == '0 ? LW_HEAD_SKIP : LW_PREV_SKIP;
               end
               state_in = S_MAX_START;
            end else if (stat.steps >= STEP_BITS'(SLOT_COUNT - 1)) begin
               ctrl.status = ST_NOTFOUND;
               state_in    = S_MAX_START;
            end else begin
               ctrl.save_prev = 1'b1;
               ctrl.psel      = PSEL_NEXT;
            end
         end
         S_MAX_START: begin
            ctrl.psel     = PSEL_HEAD;
            ctrl.max_init = 1'b1;
            state_in      = S_MAX_WALK;
         end
         S_MAX_WALK: begin
            ctrl.max_update = 1'b1;
            if (stat.cur_nil || stat.steps >= STEP_BITS'(SLOT_COUNT)) state_in = S_RESULT;
            else ctrl.psel = PSEL_NEXT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.rsp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/array_linked_list_manager_unit.sv -----
// ----------------------------------------------------------------------------
// array_linked_list_manager_unit
// singly linked list of signed values in slot memories with a head pointer
// ----------------------------------------------------------------------------
// req channel: command (insert front/back, delete front/back/value, search)
// and value; rsp channel: status, slot, removed value, count, max, empty
// one transaction at a time: a command is taken only while no other is at
// work; a finished result sits in an output register, so the next command
// is taken while that result still waits
// after acceptance a command first walks the chain as its kind needs: not at
// all for insert front, delete front, an empty list or rejected and unused
// commands, to the last link for insert back and delete back, up to the
// match for delete value and search; the walk follows one link per cycle;
// then the whole list is scanned for the maximum before the result loads
// reset: list empty, all slots free, no result pending
// receiver stall: the result holds; a following command is worked but
// waits to load its result until the previous one is taken
// ----------------------------------------------------------------------------
module array_linked_list_manager_unit (
   input  logic clock,
   input  logic reset,
   alm_req_if.sink   req,
   alm_rsp_if.source rsp
);
   import alm_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   alm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   alm_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .in_command  (req.command),
      .in_value    (req.value),
      .ctrl        (ctrl),
      .stat        (stat),
      .out_status  (rsp.status),
      .out_slot    (rsp.slot_index),
      .out_removed (rsp.removed_value),
      .out_count   (rsp.element_count),
      .out_max     (rsp.max_value),
      .out_empty   (rsp.list_empty)
   );

endmodule

// ----- verif/alm_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_list_checker
// watches the command and result channels of the linked list manager, keeps
// its own copy of the list, works out each result and compares field by field
// ----------------------------------------------------------------------------
module alm_list_checker
   import alm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   alm_req_if   req,
   alm_rsp_if   rsp,
   output int   fail_count,
   output int   results_pending,
   output int   results_seen
);

   typedef struct {
      logic [1:0]         status;
      logic [3:0]         slot_index;
      logic signed [31:0] removed_value;
      logic [4:0]         element_count;
      logic signed [31:0] max_value;
      logic               list_empty;
   } list_result_type;

   logic signed [31:0] slot_val [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] slot_used;
   int chain [$];
   list_result_type pending_results [$];

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic list_result_type list_apply(input logic [2:0] c,
                                                  input logic signed [31:0] v);
      list_result_type r;
      int s;
      int k;
      r = '{default: '0};
      case (c)
         CMD_INS_FRONT, CMD_INS_BACK: begin
            s = -1;
            for (int i = SLOT_COUNT - 1; i >= 0; i--) if (!slot_used[i]) s = i;
            if (s < 0) begin
               r.status = ST_FULL;
            end else begin
               slot_used[s] = 1'b1;
               slot_val[s] = v;
               if (c == CMD_INS_FRONT) chain.push_front(s);
               else chain.push_back(s);
               r.slot_index = 4'(s);
            end
         end
         CMD_DEL_FRONT, CMD_DEL_BACK: begin
            if (chain.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               s = (c == CMD_DEL_FRONT) ? chain.pop_front() : chain.pop_back();
               slot_used[s] = 1'b0;
               r.slot_index = 4'(s);
               r.removed_value = slot_val[s];
            end
         end
         CMD_DEL_VALUE, CMD_SEARCH: begin
            if (c == CMD_DEL_VALUE && chain.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               k = -1;
               for (int i = chain.size() - 1; i >= 0; i--)
                  if (slot_val[chain[i]] == v) k = i;
               if (k < 0) begin
                  r.status = ST_NOTFOUND;
               end else begin
                  r.slot_index = 4'(chain[k]);
                  if (c == CMD_DEL_VALUE) begin
                     slot_used[chain[k]] = 1'b0;
                     chain.delete(k);
                  end
               end
            end
         end
         default: ;
      endcase
      r.element_count = 5'(chain.size());
      r.list_empty = (chain.size() == 0);
      if (chain.size() > 0) begin
         r.max_value = slot_val[chain[0]];
         foreach (chain[i]) if (slot_val[chain[i]] > r.max_value) r.max_value = slot_val[chain[i]];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         slot_used = '0;
         chain.delete();
         pending_results.delete();
         results_seen = 0;
         fail_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $display("unexpected result transaction at %0t", $realtime);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp.status !== want.status) report("status", rsp.status, want.status);
               if (rsp.slot_index !== want.slot_index)
                  report("slot_index", rsp.slot_index, want.slot_index);
               if (rsp.removed_value !== want.removed_value)
                  report("removed_value", rsp.removed_value, want.removed_value);
               if (rsp.element_count !== want.element_count)
                  report("element_count", rsp.element_count, want.element_count);
               if (rsp.max_value !== want.max_value)
                  report("max_value", rsp.max_value, want.max_value);
               if (rsp.list_empty !== want.list_empty)
                  report("list_empty", rsp.list_empty, want.list_empty);
            end
         end
         if (req.valid && req.ready)
            pending_results.push_back(list_apply(req.command, req.value));
      end
      results_pending = pending_results.size();
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives commands into the linked list manager under several idling patterns;
// directed corner cases (empty, full, extremes, duplicates, unused codes) come
// first, then random traffic biased to fill and drain the list
// ----------------------------------------------------------------------------
module tb;
   import alm_pkg::*;

   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock;
   logic reset;
   int   idle_mode;
   int   fail_count;
   int   results_pending;
   int   results_seen;
   int   quiet_cycles;
   int   items_sent;
   logic signed [31:0] value_pool [8];

   alm_req_if req ();
   alm_rsp_if rsp ();

   array_linked_list_manager_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   alm_list_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req             (req),
      .rsp             (rsp),
      .fail_count      (fail_count),
      .results_pending (results_pending),
      .results_seen    (results_seen)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) begin
         rsp.ready <= ($urandom_range(99) >= 68);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", results_pending);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_command(input logic [2:0] c, input logic signed [31:0] v);
      int gap;
      gap = (idle_mode == IDLE_SEND) ? 68 : (idle_mode == IDLE_BOTH) ? 37 : 0;
      while ($urandom_range(99) < gap) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.command <= c;
      req.value <= v;
      do @(posedge clock); while (!req.ready);
      items_sent++;
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return value_pool[$urandom_range(7)];
         5:             return 32'sh8000_0000;
         6:             return 32'sh7fff_ffff;
         default:       return $urandom;
      endcase
   endfunction

   initial begin
      logic [2:0] c;
      int fill_bias;
      value_pool = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 5, -7, 1000};
      idle_mode = IDLE_NONE;
      items_sent = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.command = '0;
      req.value = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // operations on an empty list and unused codes
      send_command(CMD_DEL_FRONT, 0);
      send_command(CMD_DEL_BACK, 0);
      send_command(CMD_DEL_VALUE, 3);
      send_command(CMD_SEARCH, 3);
      send_command(3'd6, 32'sh7fff_ffff);
      send_command(3'd7, 32'sh8000_0000);
      // extremes and duplicates, filled past capacity
      send_command(CMD_INS_FRONT, 32'sh8000_0000);
      send_command(CMD_INS_BACK, 32'sh7fff_ffff);
      send_command(CMD_INS_BACK, 5);
      send_command(CMD_INS_FRONT, 5);
      for (int i = 0; i < 13; i++) send_command(i[0] ? CMD_INS_BACK : CMD_INS_FRONT, -i);
      send_command(CMD_SEARCH, 5);
      send_command(CMD_DEL_VALUE, 5);
      send_command(CMD_DEL_VALUE, 12345);
      send_command(CMD_DEL_BACK, 0);
      send_command(CMD_DEL_FRONT, 0);
      send_command(CMD_INS_BACK, -1);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         idle_mode = phase;
         for (int n = 0; n < 100; n++) begin
            fill_bias = (n % 40 < 20) ? 70 : 25;
            if ($urandom_range(99) < 3) c = 3'(6 + $urandom_range(1));
            else if ($urandom_range(99) < fill_bias) c = 3'($urandom_range(1));
            else c = 3'(2 + $urandom_range(3));
            send_command(c, pick_value());
         end
         drain_results();
      end

      repeat (60) @(posedge clock);
      $display("sent %0d commands, checked %0d results", items_sent, results_seen);
      $display("idling phases: none, sender, receiver, both; list filled and drained");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
